### hdl/cpc_pkg.sv
// Shared types, widths, register indexes and reset values for the contrast pixel counter.
// No dependencies; compile first.
package cpc_pkg;

    localparam int PIXEL_W    = 8;
    localparam int COUNT_W    = 18;
    localparam int THR_W      = 8;
    localparam int WIDTH_W    = 10;
    localparam int HEIGHT_W   = 9;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 2;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam logic [THR_W-1:0]    THRESHOLD_RST = 8'd128;
    localparam logic [WIDTH_W-1:0]  WIDTH_RST     = 10'd320;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST    = 9'd200;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD    = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } cfg_index_t;

    // True when |a - b| is strictly above the threshold
    function automatic logic contrasts(input logic [PIXEL_W-1:0] a,
                                       input logic [PIXEL_W-1:0] b,
                                       input logic [THR_W-1:0]   thr);
        logic [PIXEL_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return (d > thr);
    endfunction

endpackage

### hdl/cpc_pixel_if.sv
// Pixel input channel: valid/ready handshake carrying one greyscale pixel.
// Depends on cpc_pkg.
interface cpc_pixel_if;
    import cpc_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

### hdl/cpc_result_if.sv
// Result channel: valid/ready handshake carrying the running count and frame end flag.
// Depends on cpc_pkg.
interface cpc_result_if;
    import cpc_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] contrast_count;
    logic               frame_done;

    modport source (output valid, output contrast_count, output frame_done, input ready);
    modport sink   (input valid, input contrast_count, input frame_done, output ready);
endinterface

### hdl/cpc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hdl/contrast_pixel_counter_top.sv
// Contrast pixel counter: one pixel per cycle while result_out is not stalled; a taken request
// is registered through the line-store read and compare stage, then into the output register.
// Throughput is one pixel per cycle while result_out is ready, set by one read and one write per line store per pixel.
// Reset (rst_n, async low) clears position, count, pipeline and config to defaults;
// line stores are not cleared and need no clearing pass.
module contrast_pixel_counter_top #(
    parameter int MAX_WIDTH  = cpc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cpc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cpc_pkg::CFG_DATA_W-1:0] cfg_data,
    cpc_pixel_if.sink                      pixel_in,
    cpc_result_if.source                   result_out
);
    import cpc_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    // Configuration registers
    logic [THR_W-1:0]    threshold_reg;
    logic [WIDTH_W-1:0]  img_width_reg;
    logic [HEIGHT_W-1:0] img_height_reg;

    // Frame position and count
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COUNT_W-1:0] count_reg;
    logic [PIXEL_W-1:0] left_pixel_reg;
    logic               left_flag_reg;

    // Compare stage
    logic               s1_valid_reg;
    logic [PIXEL_W-1:0] s1_pixel_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic               s1_has_up_reg;
    logic               s1_has_left_reg;
    logic               s1_last_col_reg;
    logic               s1_last_row_reg;

    // Forwarding around the line stores
    logic               pix_fwd_valid_reg;
    logic [PIXEL_W-1:0] pix_fwd_data_reg;
    logic               flag_fwd_valid_reg;
    logic               flag_fwd_data_reg;
    logic               pend_valid_reg;
    logic [COL_W-1:0]   pend_addr_reg;
    logic               pend_data_reg;

    // Output register
    logic               out_valid_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_done_reg;

    logic [COL_W-1:0]   last_col_idx, cur_col;
    logic [ROW_W-1:0]   last_row_idx, cur_row;
    logic               is_last_col, is_last_row;
    logic               in_fire, s1_fire;

    logic [PIXEL_W-1:0] pix_rdata, up_pixel;
    logic [0:0]         flag_rdata;
    logic               flag_we, flag_wdata, up_flag;
    logic [COL_W-1:0]   flag_waddr;

    logic               up_hit, left_hit, cur_flag, left_full;
    logic               inc_up, inc_left, inc_last, frame_end;
    logic [1:0]         incs;
    logic [COUNT_W-1:0] count_sum;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= THRESHOLD_RST;
            img_width_reg  <= WIDTH_RST;
            img_height_reg <= HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_THRESHOLD:    threshold_reg  <= cfg_data[THR_W-1:0];
                CFG_IMAGE_WIDTH:  img_width_reg  <= cfg_data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: img_height_reg <= cfg_data[HEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Clamp frame size to 1..MAX and form last column/row indexes
    always_comb
    begin
        if (img_width_reg == '0)
            last_col_idx = '0;
        else if (32'(img_width_reg) > MAX_WIDTH)
            last_col_idx = COL_W'(MAX_WIDTH - 1);
        else
            last_col_idx = COL_W'(32'(img_width_reg) - 32'd1);

        if (img_height_reg == '0)
            last_row_idx = '0;
        else if (32'(img_height_reg) > MAX_HEIGHT)
            last_row_idx = ROW_W'(MAX_HEIGHT - 1);
        else
            last_row_idx = ROW_W'(32'(img_height_reg) - 32'd1);
    end

    // Current position, pulled in if the size shrank mid-frame
    always_comb
    begin
        cur_col     = (col_reg > last_col_idx) ? last_col_idx : col_reg;
        cur_row     = (row_reg > last_row_idx) ? last_row_idx : row_reg;
        is_last_col = (cur_col == last_col_idx);
        is_last_row = (cur_row == last_row_idx);
    end

    // Next position after this request
    always_comb
    begin
        col_next = COL_W'(cur_col + 1'b1);
        row_next = cur_row;
        if (is_last_col && is_last_row)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (is_last_col)
        begin
            col_next = '0;
            row_next = ROW_W'(cur_row + 1'b1);
        end
    end

    // Handshakes
    assign s1_fire        = s1_valid_reg && (!out_valid_reg || result_out.ready);
    assign pixel_in.ready = !s1_valid_reg || s1_fire;
    assign in_fire        = pixel_in.valid && pixel_in.ready;

    // Line stores
    cpc_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_pix_ram (
        .clk   (clk),
        .we    (s1_fire),
        .waddr (s1_col_reg),
        .wdata (s1_pixel_reg),
        .re    (in_fire),
        .raddr (cur_col),
        .rdata (pix_rdata)
    );

    // Flag writes: the left neighbor's flag, else a deferred last-column flag
    always_comb
    begin
        flag_we    = 1'b0;
        flag_waddr = pend_addr_reg;
        flag_wdata = pend_data_reg;
        if (s1_fire && s1_has_left_reg)
        begin
            flag_we    = 1'b1;
            flag_waddr = COL_W'(s1_col_reg - 1'b1);
            flag_wdata = left_full;
        end
        else if (pend_valid_reg)
        begin
            flag_we = 1'b1;
        end
    end

    cpc_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_flag_ram (
        .clk   (clk),
        .we    (flag_we),
        .waddr (flag_waddr),
        .wdata (flag_wdata),
        .re    (in_fire),
        .raddr (cur_col),
        .rdata (flag_rdata)
    );

    // Up neighbor data with write forwarding
    always_comb
    begin
        up_pixel = pix_fwd_valid_reg ? pix_fwd_data_reg : pix_rdata;
        if (pend_valid_reg && (pend_addr_reg == s1_col_reg))
            up_flag = pend_data_reg;
        else if (flag_fwd_valid_reg)
            up_flag = flag_fwd_data_reg;
        else
            up_flag = flag_rdata[0];
    end

    // Compare and count
    always_comb
    begin
        up_hit    = s1_has_up_reg && contrasts(s1_pixel_reg, up_pixel, threshold_reg);
        left_hit  = s1_has_left_reg && contrasts(s1_pixel_reg, left_pixel_reg, threshold_reg);
        left_full = left_flag_reg | left_hit;
        cur_flag  = up_hit | left_hit;
        inc_up    = s1_has_up_reg && (up_flag || up_hit);
        inc_left  = s1_has_left_reg && s1_last_row_reg && left_full;
        inc_last  = s1_last_col_reg && s1_last_row_reg && cur_flag;
        frame_end = s1_last_col_reg && s1_last_row_reg;
        incs      = {1'b0, inc_up} + {1'b0, inc_left} + {1'b0, inc_last};
        count_sum = count_reg + COUNT_W'(incs);
    end

    // Position and accept stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // Stage payload and forwarding captures
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pixel_reg       <= pixel_in.pixel;
            s1_col_reg         <= cur_col;
            s1_has_up_reg      <= (cur_row != '0);
            s1_has_left_reg    <= (cur_col != '0);
            s1_last_col_reg    <= is_last_col;
            s1_last_row_reg    <= is_last_row;
            pix_fwd_valid_reg  <= s1_fire && (s1_col_reg == cur_col);
            pix_fwd_data_reg   <= s1_pixel_reg;
            flag_fwd_valid_reg <= flag_we && (flag_waddr == cur_col);
            flag_fwd_data_reg  <= flag_wdata;
        end
        else if (s1_valid_reg && !s1_fire && flag_we && (flag_waddr == s1_col_reg))
        begin
            flag_fwd_valid_reg <= 1'b1;
            flag_fwd_data_reg  <= flag_wdata;
        end
    end

    // Running state updated as each pixel completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            left_pixel_reg <= '0;
            left_flag_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s1_fire)
            begin
                count_reg      <= frame_end ? '0 : count_sum;
                left_pixel_reg <= s1_pixel_reg;
                left_flag_reg  <= cur_flag;
                out_valid_reg  <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // last column has no right neighbor: its flag goes out next cycle
            if (s1_fire && s1_last_col_reg)
                pend_valid_reg <= 1'b1;
            else if (!(s1_fire && s1_has_left_reg))
                pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_count_reg <= count_sum;
            out_done_reg  <= frame_end;
            if (s1_last_col_reg)
            begin
                pend_addr_reg <= s1_col_reg;
                pend_data_reg <= cur_flag;
            end
        end
    end

    assign result_out.valid          = out_valid_reg;
    assign result_out.contrast_count = out_count_reg;
    assign result_out.frame_done     = out_done_reg;

endmodule

### hdl/cpc_checker.sv
// Port-level assertions for the contrast pixel counter, bound to the top level.
// Depends on cpc_pkg and contrast_pixel_counter_top.
module cpc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [cpc_pkg::COUNT_W-1:0]   out_count,
    input logic                          out_done
);
    import cpc_pkg::*;

    logic [2:0]         outstanding_reg;
    logic               have_prev_reg;
    logic               prev_done_reg;
    logic [COUNT_W-1:0] prev_count_reg;
    logic               in_fire, out_fire, step_ok;
    logic [COUNT_W-1:0] delta;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign delta    = COUNT_W'(out_count - prev_count_reg);
    assign step_ok  = prev_done_reg ? (out_count <= COUNT_W'(3)) : (delta <= COUNT_W'(3));

    // Requests taken but not yet delivered, and the last delivered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
            have_prev_reg   <= 1'b0;
            prev_done_reg   <= 1'b0;
            prev_count_reg  <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_reg + 3'(in_fire) - 3'(out_fire);
            if (out_fire)
            begin
                have_prev_reg  <= 1'b1;
                prev_done_reg  <= out_done;
                prev_count_reg <= out_count;
            end
        end
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_count) && $stable(out_done)))
        else $error("result changed while stalled");

    // No result without a pending request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (outstanding_reg != 3'd0))
        else $error("result without request");

    // At most two requests in flight (compare stage and output register)
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= 3'd2)
        else $error("too many requests in flight");

    // Count grows by at most three per pixel and restarts after frame end
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && have_prev_reg) |-> step_ok)
        else $error("count stepped by more than three");

endmodule

bind contrast_pixel_counter_top cpc_checker u_cpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pixel_in.valid),
    .in_ready  (pixel_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .out_count (result_out.contrast_count),
    .out_done  (result_out.frame_done)
);
